// ===== rtl/pnvw_pkg.sv =====
package pnvw_pkg;

  // Framebuffer geometry
  localparam int FbLines     = 512;
  localparam int MaxRowWords = 256;

  // Register indexes on the configuration port
  localparam logic [2:0] CfgPaletteSelect = 3'd0;
  localparam logic [2:0] CfgRowWords      = 3'd1;
  localparam logic [2:0] CfgUserColors0   = 3'd2;
  localparam logic [2:0] CfgUserColors1   = 3'd3;
  localparam logic [2:0] CfgUserColors2   = 3'd4;
  localparam logic [2:0] CfgUserColors3   = 3'd5;
  localparam logic [2:0] CfgUserColors4   = 3'd6;
  localparam logic [2:0] CfgUserColors5   = 3'd7;

  typedef enum logic [1:0] {
    PalStandard  = 2'd0,
    PalAlternate = 2'd1,
    PalUser      = 2'd2
  } pnvw_pal_sel_e;

  localparam logic [23:0] StdPal [16] = '{
    24'h000000, 24'hFFFFFF, 24'h68372B, 24'h70A4B2, 24'h6F3D86, 24'h588D43,
    24'h352879, 24'hB8C76F, 24'h6F4F25, 24'h433900, 24'h9A6759, 24'h444444,
    24'h6C6C6C, 24'h9AD284, 24'h6C5EB5, 24'h959595
  };

  localparam logic [23:0] AltPal [16] = '{
    24'h060A0B, 24'hF2F1F1, 24'hB63C47, 24'hA2F7ED, 24'hAF45D7, 24'h86F964,
    24'h003AF2, 24'hF8FE8A, 24'hD06E28, 24'h794E00, 24'hFB918F, 24'h5E6E69,
    24'hA3B6AD, 24'hD1FCC5, 24'h6EB3FF, 24'hDCE2DB
  };

  typedef struct packed {
    logic [7:0] packet_byte;
    logic       last_byte;
  } pnvw_in_t;

  typedef struct packed {
    logic [16:0] fb_address;
    logic [63:0] pixel_pair;
    logic        write_enable;
    logic        seq_gap;
    logic        frame_end;
  } pnvw_out_t;

  // One payload word handed from the parser stage to the write stage
  typedef struct packed {
    logic [15:0] row;
    logic [8:0]  col;
    logic [7:0]  pixels;
    logic        we;
    logic        gap;
    logic        frame_end;
  } pnvw_job_t;

endpackage

// ===== rtl/pnvw_palette.sv =====
module pnvw_palette (
  input  logic [1:0]   sel_i,
  input  logic [383:0] user_pal_i,
  input  logic [3:0]   index_i,
  output logic [31:0]  rgba_o
);
  import pnvw_pkg::*;

  logic [23:0] color;

  always_comb begin
    case (sel_i)
      PalAlternate: color = AltPal[index_i];
      PalUser:      color = user_pal_i[24 * index_i +: 24];
      default:      color = StdPal[index_i];
    endcase
  end

  // Alpha is always opaque
  assign rgba_o = {color, 8'hff};

endmodule

// ===== rtl/pnvw_parser.sv =====
module pnvw_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pnvw_pkg::pnvw_in_t  in_data_i,
  input  logic [8:0]          pitch_i,
  output logic                job_valid_o,
  input  logic                job_ready_i,
  output pnvw_pkg::pnvw_job_t job_o
);
  import pnvw_pkg::*;

  localparam logic [3:0] HeaderBytes = 4'd12;
  localparam logic [3:0] HdrSeqLo    = 4'd0;
  localparam logic [3:0] HdrSeqHi    = 4'd1;
  localparam logic [3:0] HdrLineLo   = 4'd4;
  localparam logic [3:0] HdrLineHi   = 4'd5;
  localparam logic [3:0] HdrPplLo    = 4'd6;
  localparam logic [3:0] HdrPplHi    = 4'd7;
  localparam logic [3:0] HdrLines    = 4'd8;

  logic [3:0]  hdr_cnt_q, hdr_cnt_d;
  logic [15:0] seq_q, seq_d, line_q, line_d, ppl_q, ppl_d, prev_seq_q, prev_seq_d;
  logic [7:0]  lpp_q, lpp_d, loff_q, loff_d;
  logic        gap_q, gap_d;
  logic [14:0] col_q, col_d;
  logic        job_valid_q;
  pnvw_job_t   job_q, job_d;

  logic        accept, emit, active;
  logic [14:0] hppl;
  logic [15:0] row, col_inc;
  logic        new_gap;

  assign in_ready_o = !job_valid_q || job_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign hppl    = ppl_q[15:1];
  assign active  = (loff_q < lpp_q) && (col_q < hppl);
  assign row     = {1'b0, line_q[14:0]} + {8'b0, loff_q};
  assign col_inc = {1'b0, col_q} + 16'd1;
  assign new_gap = (prev_seq_q + 16'd1) != seq_q;

  always_comb begin
    hdr_cnt_d  = hdr_cnt_q;
    seq_d      = seq_q;
    line_d     = line_q;
    ppl_d      = ppl_q;
    lpp_d      = lpp_q;
    prev_seq_d = prev_seq_q;
    gap_d      = gap_q;
    col_d      = col_q;
    loff_d     = loff_q;
    emit       = 1'b0;
    job_d      = job_q;
    if (accept) begin
      if (hdr_cnt_q != HeaderBytes) begin
        case (hdr_cnt_q)
          HdrSeqLo:  seq_d[7:0]   = in_data_i.packet_byte;
          HdrSeqHi:  seq_d[15:8]  = in_data_i.packet_byte;
          HdrLineLo: line_d[7:0]  = in_data_i.packet_byte;
          HdrLineHi: line_d[15:8] = in_data_i.packet_byte;
          HdrPplLo:  ppl_d[7:0]   = in_data_i.packet_byte;
          HdrPplHi:  ppl_d[15:8]  = in_data_i.packet_byte;
          HdrLines:  lpp_d        = in_data_i.packet_byte;
          default: ;
        endcase
        if (hdr_cnt_q == HeaderBytes - 4'd1) begin
          // Header complete: check sequence, start payload at origin
          gap_d      = new_gap;
          prev_seq_d = seq_q;
          col_d      = '0;
          loff_d     = '0;
          hdr_cnt_d  = HeaderBytes;
          if (in_data_i.last_byte) begin
            // Empty payload still reports gap and frame end
            emit            = 1'b1;
            job_d           = '0;
            job_d.gap       = new_gap;
            job_d.frame_end = line_q[15];
            hdr_cnt_d       = '0;
          end
        end else begin
          hdr_cnt_d = hdr_cnt_q + 4'd1;
          if (in_data_i.last_byte) begin
            // Truncated header: drop the packet
            hdr_cnt_d = '0;
            col_d     = '0;
            loff_d    = '0;
          end
        end
      end else begin
        emit            = 1'b1;
        job_d.row       = row;
        job_d.col       = col_q[8:0];
        job_d.pixels    = in_data_i.packet_byte;
        job_d.we        = active && (int'(row) < FbLines)
                          && (col_q < {6'b0, pitch_i});
        job_d.gap       = gap_q;
        job_d.frame_end = in_data_i.last_byte && line_q[15];
        if (active) begin
          if (col_inc >= {1'b0, hppl}) begin
            col_d = '0;
            if (loff_q != 8'hff) loff_d = loff_q + 8'd1;
          end else begin
            col_d = col_inc[14:0];
          end
        end
        if (in_data_i.last_byte) begin
          hdr_cnt_d = '0;
          col_d     = '0;
          loff_d    = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_cnt_q   <= '0;
      seq_q       <= '0;
      line_q      <= '0;
      ppl_q       <= '0;
      lpp_q       <= '0;
      prev_seq_q  <= '0;
      gap_q       <= 1'b0;
      col_q       <= '0;
      loff_q      <= '0;
      job_valid_q <= 1'b0;
    end else begin
      hdr_cnt_q  <= hdr_cnt_d;
      seq_q      <= seq_d;
      line_q     <= line_d;
      ppl_q      <= ppl_d;
      lpp_q      <= lpp_d;
      prev_seq_q <= prev_seq_d;
      gap_q      <= gap_d;
      col_q      <= col_d;
      loff_q     <= loff_d;
      if (in_ready_o) job_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) job_q <= job_d;
  end

  assign job_valid_o = job_valid_q;
  assign job_o       = job_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hdr_cnt_q <= HeaderBytes)
    else $error("header count beyond header length");

  a_job_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_q && !job_ready_i |=> job_valid_q && $stable(job_q))
    else $error("stalled job word lost or changed");

  a_col_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hdr_cnt_q == HeaderBytes) && (col_q != '0) |-> col_q < hppl)
    else $error("pair column outside line");

  a_hdr_col_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hdr_cnt_q != HeaderBytes) |-> (col_q == '0) && (loff_q == '0))
    else $error("payload position not cleared during header");

endmodule

// ===== rtl/packed_nibble_video_packet_writer.sv =====
// Packed-nibble video packet writer. Feed a packet one byte per word on the
// input channel: a 12-byte little-endian header (seq, frame, line with the
// frame-end flag in bit 15, pixels per line, lines in packet, bpp, encoding)
// followed by payload bytes that each carry two 4-bit color indices. Every
// payload byte yields one output word: a 64-bit framebuffer write of two RGBA
// pixels (high nibble in bits 63..32) at row * min(row_words, 256) + pair
// column, with write_enable low (address and data zero) when the byte falls
// outside the packet's lines or the framebuffer. A header that ends with the
// last byte yields one word with write_enable low carrying seq_gap and
// frame_end; a truncated header yields nothing. The block takes one byte
// every cycle while its output is not stalled; a result passes a register
// stage for header parsing and position tracking, then one for the address
// multiply and palette lookup. Write configuration only while the block is idle.
module packed_nibble_video_packet_writer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pnvw_pkg::pnvw_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pnvw_pkg::pnvw_out_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [63:0]         cfg_wdata_i
);
  import pnvw_pkg::*;

  // Configuration registers
  logic [1:0]   pal_sel_q;
  logic [8:0]   row_words_q;
  logic [383:0] user_pal_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pal_sel_q   <= PalStandard;
      row_words_q <= 9'd192;
      user_pal_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgPaletteSelect: pal_sel_q           <= cfg_wdata_i[1:0];
        CfgRowWords:      row_words_q         <= cfg_wdata_i[8:0];
        CfgUserColors0:   user_pal_q[63:0]    <= cfg_wdata_i;
        CfgUserColors1:   user_pal_q[127:64]  <= cfg_wdata_i;
        CfgUserColors2:   user_pal_q[191:128] <= cfg_wdata_i;
        CfgUserColors3:   user_pal_q[255:192] <= cfg_wdata_i;
        CfgUserColors4:   user_pal_q[319:256] <= cfg_wdata_i;
        CfgUserColors5:   user_pal_q[383:320] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Clamp the pitch to the widest supported line
  logic [8:0] pitch;
  assign pitch = (int'(row_words_q) > MaxRowWords) ? 9'(MaxRowWords) : row_words_q;

  // Stage one: header parsing and payload position
  logic      job_valid, job_ready;
  pnvw_job_t job;

  pnvw_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .pitch_i     (pitch),
    .job_valid_o (job_valid),
    .job_ready_i (job_ready),
    .job_o       (job)
  );

  // Stage two: palette lookup for both nibbles, in parallel with the address
  logic [31:0] rgba_hi, rgba_lo;

  pnvw_palette u_pal_hi (
    .sel_i      (pal_sel_q),
    .user_pal_i (user_pal_q),
    .index_i    (job.pixels[7:4]),
    .rgba_o     (rgba_hi)
  );

  pnvw_palette u_pal_lo (
    .sel_i      (pal_sel_q),
    .user_pal_i (user_pal_q),
    .index_i    (job.pixels[3:0]),
    .rgba_o     (rgba_lo)
  );

  // Word address: row times pitch plus column, kept to the address width
  logic [24:0] addr_full;
  assign addr_full = 25'(job.row) * 25'(pitch) + 25'(job.col);

  pnvw_out_t out_d, out_q;
  logic      out_valid_q;

  always_comb begin
    out_d              = '0;
    out_d.write_enable = job.we;
    out_d.seq_gap      = job.gap;
    out_d.frame_end    = job.frame_end;
    // Drive zero address and data on a suppressed write
    if (job.we) begin
      out_d.fb_address = addr_full[16:0];
      out_d.pixel_pair = {rgba_hi, rgba_lo};
    end
  end

  // Output register: advance whenever it is empty or being drained
  assign job_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (job_ready) begin
      out_valid_q <= job_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_ready) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_suppressed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.write_enable
      |-> (out_data_o.fb_address == '0) && (out_data_o.pixel_pair == '0))
    else $error("suppressed word carries address or data");

  a_alpha_opaque: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.write_enable
      |-> (out_data_o.pixel_pair[7:0] == 8'hff) && (out_data_o.pixel_pair[39:32] == 8'hff))
    else $error("pixel alpha not opaque");

  a_job_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid && job_ready |=> out_valid_q)
    else $error("parsed word not taken into output register");

endmodule
